@@ rtl/ptpd_pkg.sv @@
// Package for the per-thread print deframer.
// Holds the per-thread parser phase codes, the state entry type and defaults.
// No dependencies.
`timescale 1ns / 1ps

package ptpd_pkg;

	localparam int THREADS_DEF = 8;
	localparam int TID_W = 3;
	localparam int WORD_W = 32;
	localparam int CNT_W = 3;
	localparam int PH_W = 2;
	localparam int OUT_TDATA_W = 72;

	localparam logic [PH_W-1:0] PH_DELIM = 2'd0;
	localparam logic [PH_W-1:0] PH_DESC = 2'd1;
	localparam logic [PH_W-1:0] PH_DATA = 2'd2;

	localparam logic [WORD_W-1:0] DELIM_RESET = 32'hFFFF_FFFF;
	localparam logic [7:0] ZERO_BYTE = 8'h00;
	localparam logic [CNT_W-1:0] CNT_NONE = 3'd4;

	typedef struct packed {
		logic [WORD_W-1:0] desc;
		logic [PH_W-1:0] after_delim;
		logic [PH_W-1:0] phase;
	} ptpd_entry_t;

	localparam ptpd_entry_t ENTRY_RESET = '{desc: '0, after_delim: PH_DESC, phase: PH_DELIM};

	typedef struct packed {
		logic valid;
		logic [CNT_W-1:0] char_count;
		logic end_of_message;
	} ptpd_result_t;

endpackage

@@ rtl/ptpd_state_mem.sv @@
// Per-thread state memory with registered read.
// Entries never written read back as the reset entry through per-entry valid bits.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps

module ptpd_state_mem
	import ptpd_pkg::*;
#(
	parameter int THREADS = THREADS_DEF,
	parameter int IW = (THREADS > 1) ? $clog2(THREADS) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [IW-1:0] rd_idx,
	output ptpd_entry_t rd_entry,
	input  logic wr_en,
	input  logic [IW-1:0] wr_idx,
	input  ptpd_entry_t wr_entry
);

	ptpd_entry_t mem [THREADS];
	logic [THREADS-1:0] written_q;
	ptpd_entry_t rd_data_q;
	logic rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_idx];
			end
		end
	end

	assign rd_entry = rd_written_q ? rd_data_q : ENTRY_RESET;

endmodule

@@ rtl/ptpd_parser.sv @@
// Next-state and result logic of one thread's three-phase parser.
// Finds the first zero byte of a text word. Depends on ptpd_pkg.
`timescale 1ns / 1ps

module ptpd_parser
	import ptpd_pkg::*;
(
	input  ptpd_entry_t cur,
	input  logic [WORD_W-1:0] word,
	input  logic [WORD_W-1:0] delim,
	input  logic in_range,
	output ptpd_entry_t nxt,
	output ptpd_result_t res
);

	logic is_delim;
	logic [CNT_W-1:0] cnt;
	logic has_zero;
	logic emit;

	always_comb begin
		cnt = CNT_NONE;
		for (int k = 3; k >= 0; k--) begin
			if (word[8*k +: 8] == ZERO_BYTE) begin
				cnt = CNT_W'(k);
			end
		end
	end

	assign has_zero = (cnt != CNT_NONE);
	assign is_delim = (word == delim);

	always_comb begin
		nxt = cur;
		emit = 1'b0;
		unique case (cur.phase)
			PH_DELIM: begin
				if (is_delim) begin
					nxt.phase = cur.after_delim;
				end
			end
			PH_DESC: begin
				if (!is_delim) begin
					nxt.desc = word;
					nxt.phase = PH_DELIM;
					nxt.after_delim = PH_DATA;
				end
			end
			PH_DATA: begin
				if (!is_delim) begin
					emit = 1'b1;
					nxt.phase = PH_DELIM;
					if (has_zero) begin
						nxt.after_delim = PH_DESC;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign res.valid = emit && in_range;
	assign res.char_count = cnt;
	assign res.end_of_message = has_zero;

endmodule

@@ rtl/per_thread_print_deframer.sv @@
// Top level of the per-thread print deframer: input stage, state memory with
// write-back forwarding, parser and output register. Depends on ptpd_pkg,
// ptpd_state_mem and ptpd_parser.
//
// Channel  Direction  Signals                      Content
// s_*      in         tvalid tready tdata tuser    tdata: bus_word; tuser: thread_number
// m_*      out        tvalid tready tdata tuser    tdata: descriptor, text_word,
//                     tlast                        char_count; tuser: thread_out;
//                                                  tlast: end_of_message
// cfg_*    in         valid ready data             delimiter word
//
// One word is taken per cycle while s_tready is high; the word is registered in the parse stage and its result
// in the output register, from which it is offered on m_*. The state memory read is registered; the last write back is
// forwarded, so words of the same thread may follow back to back.
// Reset clears the control state and marks every thread entry as unwritten.
// A stalled output holds a word that has a result in the parse stage and drops s_tready.
`timescale 1ns / 1ps

module per_thread_print_deframer
	import ptpd_pkg::*;
#(
	parameter int THREADS = THREADS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [WORD_W-1:0] s_tdata,      // [31:0] bus_word
	input  logic [TID_W-1:0] s_tuser,       // [2:0] thread_number
	output logic m_tvalid,
	input  logic m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata, // [31:0] descriptor, [63:32] text_word,
	                                        // [66:64] char_count, [71:67] zero
	output logic [TID_W-1:0] m_tuser,       // [2:0] thread_out
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [WORD_W-1:0] cfg_data
);

	localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;

	logic [WORD_W-1:0] delim_q;
	logic v_s1;
	logic [TID_W-1:0] tid_s1;
	logic [WORD_W-1:0] word_s1;
	logic in_range_s1;
	logic wr_vld_q;
	logic [IW-1:0] wr_idx_q;
	ptpd_entry_t wr_ent_q;
	logic out_valid_q;
	logic [TID_W-1:0] out_tid_q;
	logic [WORD_W-1:0] out_desc_q;
	logic [WORD_W-1:0] out_word_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic out_eom_q;

	logic accept;
	logic out_free;
	logic s1_go;
	logic wr_en;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] idx_s1;
	ptpd_entry_t mem_entry;
	ptpd_entry_t cur_entry;
	ptpd_entry_t nxt_entry;
	ptpd_result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign s1_go = v_s1 && (!res.valid || out_free);
	assign s_tready = !v_s1 || s1_go;
	assign accept = s_tvalid && s_tready;
	assign rd_idx = IW'(s_tuser);
	assign idx_s1 = IW'(tid_s1);
	assign wr_en = s1_go && in_range_s1;

	ptpd_state_mem #(
		.THREADS(THREADS),
		.IW(IW)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_idx(rd_idx),
		.rd_entry(mem_entry),
		.wr_en(wr_en),
		.wr_idx(idx_s1),
		.wr_entry(nxt_entry)
	);

	assign cur_entry = (wr_vld_q && (wr_idx_q == idx_s1)) ? wr_ent_q : mem_entry;

	ptpd_parser u_parser (
		.cur(cur_entry),
		.word(word_s1),
		.delim(delim_q),
		.in_range(in_range_s1),
		.nxt(nxt_entry),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wr_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (wr_en) begin
				wr_vld_q <= 1'b1;
			end
			if (s1_go && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tid_s1 <= s_tuser;
			word_s1 <= s_tdata;
			in_range_s1 <= (32'(s_tuser) < THREADS);
		end
		if (wr_en) begin
			wr_idx_q <= idx_s1;
			wr_ent_q <= nxt_entry;
		end
		if (s1_go && res.valid) begin
			out_tid_q <= tid_s1;
			out_desc_q <= cur_entry.desc;
			out_word_q <= word_s1;
			out_cnt_q <= res.char_count;
			out_eom_q <= res.end_of_message;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_tid_q;
	assign m_tlast = out_eom_q;
	assign m_tdata = {5'b0, out_cnt_q, out_word_q, out_desc_q};

endmodule

@@ sim/tb_per_thread_print_deframer.sv @@
// Testbench for per_thread_print_deframer: drives tagged bus words and delimiter writes,
// predicts every text word transfer in a small scoreboard class and checks the output.
// Depends on ptpd_pkg and per_thread_print_deframer.
`timescale 1ns / 1ps

module tb_per_thread_print_deframer;
	import ptpd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SEGMENTS = 9;
	localparam int SEGMENT_ITEMS = 95;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;

	typedef struct {
		logic [TID_W-1:0] thread;
		logic [WORD_W-1:0] desc;
		logic [WORD_W-1:0] text;
		logic [CNT_W-1:0] count;
		logic eom;
	} text_result_t;

	class deframe_tracker;
		logic [WORD_W-1:0] delim;
		logic [PH_W-1:0] phase [THREADS_DEF];
		logic [PH_W-1:0] after_delim [THREADS_DEF];
		logic [WORD_W-1:0] desc [THREADS_DEF];
		text_result_t pending_words [$];
		int errors;

		function new();
			delim = DELIM_RESET;
			errors = 0;
			for (int t = 0; t < THREADS_DEF; t++) begin
				phase[t] = PH_DELIM;
				after_delim[t] = PH_DESC;
				desc[t] = '0;
			end
		endfunction

		function void set_delimiter(logic [WORD_W-1:0] value);
			delim = value;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		function void take_bus_word(logic [TID_W-1:0] tid, logic [WORD_W-1:0] w);
			text_result_t r;
			logic [CNT_W-1:0] cnt;
			cnt = CNT_NONE;
			case (phase[tid])
				PH_DELIM: begin
					if (w == delim)
						phase[tid] = after_delim[tid];
				end
				PH_DESC: begin
					if (w != delim) begin
						desc[tid] = w;
						phase[tid] = PH_DELIM;
						after_delim[tid] = PH_DATA;
					end
				end
				PH_DATA: begin
					if (w != delim) begin
						for (int k = 3; k >= 0; k--)
							if (w[8*k +: 8] == ZERO_BYTE)
								cnt = CNT_W'(k);
						phase[tid] = PH_DELIM;
						if (cnt != CNT_NONE)
							after_delim[tid] = PH_DESC;
						r.thread = tid;
						r.desc = desc[tid];
						r.text = w;
						r.count = cnt;
						r.eom = (cnt != CNT_NONE);
						pending_words.push_back(r);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
			end
		endfunction

		function void check_text_word(text_result_t got);
			text_result_t exp;
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected transfer, expected none, actual thread %0d text %h",
					$time, got.thread, got.text);
				return;
			end
			exp = pending_words.pop_front();
			compare_field("thread_out", WORD_W'(exp.thread), WORD_W'(got.thread));
			compare_field("descriptor", exp.desc, got.desc);
			compare_field("text_word", exp.text, got.text);
			compare_field("char_count", WORD_W'(exp.count), WORD_W'(got.count));
			compare_field("end_of_message", WORD_W'(exp.eom), WORD_W'(got.eom));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [WORD_W-1:0] s_tdata;
	logic [TID_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [TID_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [WORD_W-1:0] cfg_data;

	deframe_tracker tracker = new();
	text_result_t seen_result;
	int send_idle_pct = 25;
	int recv_idle_pct = 65;
	int hold_request = 0;
	int stall_cycles = 0;
	logic [TID_W+WORD_W-1:0] directed_seq [25];

	per_thread_print_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result.thread = m_tuser;
			seen_result.desc = m_tdata[31:0];
			seen_result.text = m_tdata[63:32];
			seen_result.count = m_tdata[66:64];
			seen_result.eom = m_tlast;
			tracker.check_text_word(seen_result);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("per_thread_print_deframer test failed");
				$finish;
			end
		end
	end

	initial begin : ready_driver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != hold_seen) begin
				hold_seen = hold_request;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(input logic [TID_W-1:0] tid, input logic [WORD_W-1:0] w);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= tid;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.take_bus_word(tid, w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_delimiter(input logic [WORD_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_delimiter(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] choose_word(input logic [TID_W-1:0] tid);
		logic [WORD_W-1:0] w;
		int pos;
		if ($urandom_range(99, 0) < 15) begin
			case ($urandom_range(3, 0))
				0: w = $urandom;
				1: w = tracker.delim;
				2: w = 32'h0000_0000;
				default: w = 32'hFFFF_FFFF;
			endcase
			return w;
		end
		case (tracker.phase[tid])
			PH_DELIM: w = tracker.delim;
			PH_DESC: begin
				do begin
					if ($urandom_range(9, 0) == 0)
						w = $urandom_range(1, 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
					else
						w = $urandom;
				end while (w == tracker.delim);
			end
			default: begin
				do begin
					for (int k = 0; k < 4; k++)
						w[8*k +: 8] = 8'($urandom_range(255, 1));
					if ($urandom_range(99, 0) < 25) begin
						pos = $urandom_range(3, 0);
						w[8*pos +: 8] = ZERO_BYTE;
						for (int k = pos + 1; k < 4; k++)
							if ($urandom_range(1, 0))
								w[8*k +: 8] = ZERO_BYTE;
					end
				end while (w == tracker.delim);
			end
		endcase
		return w;
	endfunction

	initial begin
		logic [TID_W-1:0] tid;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		directed_seq = '{
			{3'd7, 32'h1234_5678}, {3'd0, DELIM_RESET}, {3'd0, DELIM_RESET},
			{3'd0, 32'h0000_0000}, {3'd0, DELIM_RESET}, {3'd0, DELIM_RESET},
			{3'd0, 32'hFFFF_FFFE}, {3'd0, DELIM_RESET}, {3'd0, 32'h0003_0201},
			{3'd7, DELIM_RESET}, {3'd7, 32'hFFFF_FFFE}, {3'd0, DELIM_RESET},
			{3'd0, 32'h7FFF_FFFF}, {3'd7, DELIM_RESET}, {3'd7, 32'h0000_0001},
			{3'd0, DELIM_RESET}, {3'd0, 32'h0100_0102}, {3'd7, DELIM_RESET},
			{3'd7, 32'h8000_0000}, {3'd7, DELIM_RESET}, {3'd7, 32'h8080_8000},
			{3'd3, DELIM_RESET}, {3'd3, 32'h0000_0000}, {3'd3, DELIM_RESET},
			{3'd3, 32'h0000_0000}
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_delimiter(DELIM_RESET);
		foreach (directed_seq[i])
			send_word(directed_seq[i][TID_W+WORD_W-1:WORD_W], directed_seq[i][WORD_W-1:0]);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 3)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg % 3)
				0: write_delimiter($urandom);
				1: write_delimiter(32'h0000_0000);
				default: write_delimiter(32'hFFFF_FFFF);
			endcase
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if (seg == 6 && n == 20)
					hold_request++;
				if (seg == 7 && n == 40)
					wait_drained();
				tid = TID_W'($urandom_range(THREADS_DEF - 1, 0));
				send_word(tid, choose_word(tid));
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (tracker.pending() != 0) begin
			tracker.errors++;
			$display("%0t: results left over, expected 0, actual %0d", $time, tracker.pending());
		end
		if (tracker.errors == 0)
			$display("per_thread_print_deframer test passed");
		else
			$display("per_thread_print_deframer test failed");
		$finish;
	end

endmodule

@@ per_thread_print_deframer.f @@
rtl/ptpd_pkg.sv
rtl/ptpd_state_mem.sv
rtl/ptpd_parser.sv
rtl/per_thread_print_deframer.sv
sim/tb_per_thread_print_deframer.sv
